// ===== src/tetra_circumsphere_radius_top_assert.svh =====
// Assertion macros shared by the circumsphere radius checker.
// Expects clk and arst_n in the scope where a macro is used.
`ifndef TETRA_CIRCUMSPHERE_RADIUS_TOP_ASSERT_SVH
`define TETRA_CIRCUMSPHERE_RADIUS_TOP_ASSERT_SVH

// same-cycle implication
`define TCR_ASSERT_NOW(lbl, pre, post) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (pre) |-> (post)) \
		else $error("tcr: assertion failed");

// next-cycle implication
`define TCR_ASSERT_NEXT(lbl, pre, post) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (pre) |=> (post)) \
		else $error("tcr: assertion failed");

`endif

// ===== src/tcr_pkg.sv =====
// Types and constants for the tetrahedron circumsphere radius pipeline.
// No dependencies.
`default_nettype none

package tcr_pkg;

	localparam int CB     = 16;            // coordinate bits
	localparam int FB     = 8;             // radius fraction bits
	localparam int RB     = CB + 1 + FB;   // radius bits
	localparam int RW     = CB + 1;        // edge vector component
	localparam int SQPW   = 2 * CB - 1;    // coordinate squared
	localparam int BVW    = 2 * CB + 3;    // right-hand side term
	localparam int CFW    = 2 * RW + 1;    // cofactor
	localparam int DETW   = RW + CFW + 2;  // determinant
	localparam int NUMW   = BVW + CFW + 2; // Cramer numerator
	localparam int QB     = CB + 1;        // quotient bits kept
	localparam int DVW    = NUMW + 1;      // divider datapath
	localparam int DW     = CB + 1;        // centre minus vertex
	localparam int SSW    = 2 * DW + 2;    // sum of squares
	localparam int SQW    = 2 * RB;        // square root operand
	localparam int DIV_LAT = QB + 1;
	localparam int SQ_LAT  = RB;

	localparam int ADDR_W = 3;
	localparam logic REG_ALPHA = 1'b0;     // register index, paddr[2]
	localparam logic [RB-1:0] ALPHA_RESET = RB'(2560);

	typedef logic signed [CB-1:0] coord_t;

	typedef struct packed {
		coord_t a_x;
		coord_t a_y;
		coord_t a_z;
		coord_t b_x;
		coord_t b_y;
		coord_t b_z;
		coord_t c_x;
		coord_t c_y;
		coord_t c_z;
		coord_t d_x;
		coord_t d_y;
		coord_t d_z;
	} in_beat_t;

	typedef struct packed {
		logic [RB-1:0] radius_q8;
		coord_t        center_x;
		coord_t        center_y;
		coord_t        center_z;
		logic          within_alpha;
		logic          degenerate;
	} out_beat_t;

endpackage

`default_nettype wire

// ===== src/tcr_div_pipe.sv =====
// Pipelined restoring divider: one quotient bit per stage, truncating,
// saturated to the coordinate range. Depends on tcr_pkg.
`default_nettype none

module tcr_div_pipe (
	input  logic                        clk,
	input  logic                        en,
	input  logic [tcr_pkg::NUMW-1:0]    num,
	input  logic [tcr_pkg::DVW-1:0]     den,
	input  logic                        neg,
	output tcr_pkg::coord_t             ctr
);
	import tcr_pkg::*;

	logic [DVW-1:0] rem_s [QB+1];
	logic [DVW-1:0] dv_s  [QB+1];
	logic [QB-1:0]  q_s   [QB+1];
	logic           ng_s  [QB+1];
	logic           ovf_s [QB+1];

	logic [DVW-1:0] sh   [QB];
	logic           take [QB];

	always_comb begin
		for (int k = 0; k < QB; k++) begin
			sh[k]   = dv_s[k] << (QB - 1 - k);
			take[k] = rem_s[k] >= sh[k];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rem_s[0] <= DVW'(num);
			dv_s[0]  <= den;
			ng_s[0]  <= neg;
			q_s[0]   <= '0;
			// quotient would need more than QB bits
			ovf_s[0] <= DVW'(num) >= (den << QB);
			for (int k = 0; k < QB; k++) begin
				rem_s[k+1] <= take[k] ? rem_s[k] - sh[k] : rem_s[k];
				q_s[k+1]   <= q_s[k] | (take[k] ? (QB'(1) << (QB - 1 - k)) : '0);
				dv_s[k+1]  <= dv_s[k];
				ng_s[k+1]  <= ng_s[k];
				ovf_s[k+1] <= ovf_s[k];
			end
		end
	end

	logic [QB-1:0] limit;
	logic [QB-1:0] mag;
	logic [QB-1:0] sgn;

	always_comb begin
		limit = ng_s[QB] ? (QB'(1) << (CB - 1)) : ((QB'(1) << (CB - 1)) - QB'(1));
		mag   = (ovf_s[QB] || q_s[QB] > limit) ? limit : q_s[QB];
		sgn   = ng_s[QB] ? -mag : mag;
		ctr   = coord_t'(sgn[CB-1:0]);
	end

endmodule

`default_nettype wire

// ===== src/tcr_sqrt_pipe.sv =====
// Pipelined integer square root, one root bit per stage, floored.
// Depends on tcr_pkg.
`default_nettype none

module tcr_sqrt_pipe (
	input  logic                     clk,
	input  logic                     en,
	input  logic [tcr_pkg::SQW-1:0]  n,
	output logic [tcr_pkg::RB-1:0]   root
);
	import tcr_pkg::*;

	logic [SQW-1:0] rem_s [RB];
	logic [SQW:0]   res_s [RB];

	logic [SQW-1:0] rem_in [RB];
	logic [SQW:0]   res_in [RB];
	logic [SQW:0]   one    [RB];
	logic [SQW:0]   trial  [RB];
	logic           take   [RB];

	always_comb begin
		for (int k = 0; k < RB; k++) begin
			rem_in[k] = (k == 0) ? n : rem_s[(k == 0) ? 0 : k - 1];
			res_in[k] = (k == 0) ? '0 : res_s[(k == 0) ? 0 : k - 1];
			one[k]    = (SQW + 1)'(1) << (2 * (RB - 1 - k));
			trial[k]  = res_in[k] + one[k];
			take[k]   = {1'b0, rem_in[k]} >= trial[k];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int k = 0; k < RB; k++) begin
				rem_s[k] <= take[k] ? rem_in[k] - trial[k][SQW-1:0] : rem_in[k];
				res_s[k] <= take[k] ? (res_in[k] + (one[k] << 1)) >> 1 : res_in[k] >> 1;
			end
		end
	end

	assign root = res_s[RB-1][RB-1:0];

endmodule

`default_nettype wire

// ===== src/tetra_circumsphere_radius_top.sv =====
// Circumsphere radius of an integer tetrahedron: Cramer's rule, divide, sqrt.
// 11 datapath stages, 18 divider stages, 25 square root stages.
// Throughput one tetrahedron per cycle; the whole pipe holds while a result
// waits at the output. Reset clears valid bits and sets alpha_radius to 10.0.
// Depends on tcr_pkg, tcr_div_pipe, tcr_sqrt_pipe.
`default_nettype none

module tetra_circumsphere_radius_top (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  tcr_pkg::in_beat_t             in_data,
	output logic                          out_valid,
	input  logic                          out_ready,
	output tcr_pkg::out_beat_t            out_data,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [tcr_pkg::ADDR_W-1:0]    paddr,
	input  logic [31:0]                   pwdata,
	output logic [31:0]                   prdata,
	output logic                          pready
);
	import tcr_pkg::*;

	localparam int NST = 11 + DIV_LAT + SQ_LAT;
	localparam int AL  = 7 + DIV_LAT;
	localparam int GL  = DIV_LAT + 4 + SQ_LAT;
	localparam int CL  = SQ_LAT + 4;

	logic          en;
	logic [NST-1:0] vld_s;
	logic [RB-1:0] alpha_q;

	assign en       = out_ready || !out_valid;
	assign in_ready = en;
	assign out_valid = vld_s[NST-1];

	// config port
	assign pready = 1'b1;
	assign prdata = (paddr[2] == REG_ALPHA) ? {(32 - RB)'(0), alpha_q} : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			alpha_q <= ALPHA_RESET;
			vld_s   <= '0;
		end else begin
			if (psel && penable && pwrite && paddr[2] == REG_ALPHA)
				alpha_q <= pwdata[RB-1:0];
			if (en)
				vld_s <= {vld_s[NST-2:0], in_valid};
		end
	end

	coord_t pt [12];
	assign pt[0]  = in_data.a_x;
	assign pt[1]  = in_data.a_y;
	assign pt[2]  = in_data.a_z;
	assign pt[3]  = in_data.b_x;
	assign pt[4]  = in_data.b_y;
	assign pt[5]  = in_data.b_z;
	assign pt[6]  = in_data.c_x;
	assign pt[7]  = in_data.c_y;
	assign pt[8]  = in_data.c_z;
	assign pt[9]  = in_data.d_x;
	assign pt[10] = in_data.d_y;
	assign pt[11] = in_data.d_z;

	// s1: edge vectors and squares
	logic signed [RW-1:0]   row_s1 [3][3];
	logic [SQPW-1:0]        sqp_s1 [3][3];
	logic [SQPW-1:0]        sqd_s1 [3];
	logic signed [2*CB-1:0] psq [12];

	always_comb begin
		for (int i = 0; i < 12; i++)
			psq[i] = pt[i] * pt[i];
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				for (int j = 0; j < 3; j++) begin
					row_s1[i][j] <= RW'(pt[i*3+j]) - RW'(pt[9+j]);
					sqp_s1[i][j] <= psq[i*3+j][SQPW-1:0];
				end
				sqd_s1[i] <= psq[9+i][SQPW-1:0];
			end
		end
	end

	// s2: right-hand side and minor products
	logic signed [BVW-1:0]  bvc    [3];
	logic signed [BVW-1:0]  bv_s2  [3];
	logic signed [RW-1:0]   r0_s2  [3];
	logic signed [2*RW-1:0] pa     [3][3];
	logic signed [2*RW-1:0] pb     [3][3];
	logic signed [2*RW-1:0] pa_s2  [3][3];
	logic signed [2*RW-1:0] pb_s2  [3][3];

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			bvc[i] = '0;
			for (int j = 0; j < 3; j++)
				bvc[i] = bvc[i] + $signed(BVW'(sqp_s1[i][j])) - $signed(BVW'(sqd_s1[j]));
		end
	end

	// cyclic index form gives signed cofactors directly
	for (genvar i = 0; i < 3; i++) begin : g_row
		for (genvar j = 0; j < 3; j++) begin : g_col
			assign pa[i][j] = row_s1[(i+1)%3][(j+1)%3] * row_s1[(i+2)%3][(j+2)%3];
			assign pb[i][j] = row_s1[(i+1)%3][(j+2)%3] * row_s1[(i+2)%3][(j+1)%3];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				bv_s2[i] <= bvc[i];
				r0_s2[i] <= row_s1[i][0];
				for (int j = 0; j < 3; j++) begin
					pa_s2[i][j] <= pa[i][j];
					pb_s2[i][j] <= pb[i][j];
				end
			end
		end
	end

	// s3: cofactors
	logic signed [CFW-1:0] cof_s3 [3][3];
	logic signed [BVW-1:0] bv_s3  [3];
	logic signed [RW-1:0]  r0_s3  [3];

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				bv_s3[i] <= bv_s2[i];
				r0_s3[i] <= r0_s2[i];
				for (int j = 0; j < 3; j++)
					cof_s3[i][j] <= CFW'(pa_s2[i][j]) - CFW'(pb_s2[i][j]);
			end
		end
	end

	// s4: expansion products
	logic signed [RW+CFW-1:0]  dp    [3];
	logic signed [BVW+CFW-1:0] np    [3][3];
	logic signed [RW+CFW-1:0]  dp_s4 [3];
	logic signed [BVW+CFW-1:0] np_s4 [3][3];

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			dp[i] = r0_s3[i] * cof_s3[i][0];
			for (int c = 0; c < 3; c++)
				np[i][c] = bv_s3[i] * cof_s3[i][c];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			dp_s4 <= dp;
			np_s4 <= np;
		end
	end

	// s5: determinant and numerators
	logic signed [DETW-1:0] detc;
	logic signed [NUMW-1:0] numc [3];
	logic signed [DETW-1:0] det_s5;
	logic signed [NUMW-1:0] num_s5 [3];

	always_comb begin
		detc = '0;
		for (int i = 0; i < 3; i++)
			detc = detc + DETW'(dp_s4[i]);
		for (int c = 0; c < 3; c++) begin
			numc[c] = '0;
			for (int i = 0; i < 3; i++)
				numc[c] = numc[c] + NUMW'(np_s4[i][c]);
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			det_s5 <= detc;
			num_s5 <= numc;
		end
	end

	// s6: magnitudes and signs for the dividers
	logic [DETW-1:0] absdet;
	logic [NUMW-1:0] nmag   [3];
	logic [NUMW-1:0] nmag_s6 [3];
	logic            neg_s6 [3];
	logic [DVW-1:0]  den_s6;
	logic            degen_s6;

	always_comb begin
		absdet = det_s5[DETW-1] ? $unsigned(-det_s5) : $unsigned(det_s5);
		for (int c = 0; c < 3; c++)
			nmag[c] = num_s5[c][NUMW-1] ? $unsigned(-num_s5[c]) : $unsigned(num_s5[c]);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			den_s6   <= DVW'(absdet) << 1;
			degen_s6 <= det_s5 == '0;
			for (int c = 0; c < 3; c++) begin
				nmag_s6[c] <= nmag[c];
				neg_s6[c]  <= num_s5[c][NUMW-1] ^ det_s5[DETW-1];
			end
		end
	end

	coord_t div_ctr [3];

	for (genvar c = 0; c < 3; c++) begin : g_div
		tcr_div_pipe u_div (
			.clk (clk),
			.en  (en),
			.num (nmag_s6[c]),
			.den (den_s6),
			.neg (neg_s6[c]),
			.ctr (div_ctr[c])
		);
	end

	// side data delay lines
	coord_t ap_s [AL][3];
	logic   dg_s [GL];
	coord_t cs_s [CL][3];

	always_ff @(posedge clk) begin
		if (en) begin
			ap_s[0][0] <= in_data.a_x;
			ap_s[0][1] <= in_data.a_y;
			ap_s[0][2] <= in_data.a_z;
			for (int k = 1; k < AL; k++)
				ap_s[k] <= ap_s[k-1];
			dg_s[0] <= degen_s6;
			for (int k = 1; k < GL; k++)
				dg_s[k] <= dg_s[k-1];
			cs_s[0] <= div_ctr;
			for (int k = 1; k < CL; k++)
				cs_s[k] <= cs_s[k-1];
		end
	end

	// s8..s10: squared distance from the centre to the first vertex
	logic signed [DW-1:0]   df_s8  [3];
	logic signed [2*DW-1:0] dsq    [3];
	logic [2*DW-1:0]        dsq_s9 [3];
	logic [SSW-1:0]         ss_s10;

	always_comb begin
		for (int c = 0; c < 3; c++)
			dsq[c] = df_s8[c] * df_s8[c];
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int c = 0; c < 3; c++) begin
				df_s8[c]  <= DW'(cs_s[0][c]) - DW'(ap_s[AL-1][c]);
				dsq_s9[c] <= $unsigned(dsq[c]);
			end
			ss_s10 <= SSW'(dsq_s9[0]) + SSW'(dsq_s9[1]) + SSW'(dsq_s9[2]);
		end
	end

	logic [RB-1:0] root;

	tcr_sqrt_pipe u_sqrt (
		.clk  (clk),
		.en   (en),
		.n    (SQW'({ss_s10, (2 * FB)'(0)})),
		.root (root)
	);

	// output register
	always_ff @(posedge clk) begin
		if (en) begin
			if (dg_s[GL-1]) begin
				out_data.radius_q8    <= '0;
				out_data.center_x     <= '0;
				out_data.center_y     <= '0;
				out_data.center_z     <= '0;
				out_data.within_alpha <= 1'b0;
				out_data.degenerate   <= 1'b1;
			end else begin
				out_data.radius_q8    <= root;
				out_data.center_x     <= cs_s[CL-1][0];
				out_data.center_y     <= cs_s[CL-1][1];
				out_data.center_z     <= cs_s[CL-1][2];
				out_data.within_alpha <= root < alpha_q;
				out_data.degenerate   <= 1'b0;
			end
		end
	end

endmodule

`default_nettype wire

// ===== src/tcr_checker.sv =====
// Port-level checks for the circumsphere radius top level, bound in below.
// Depends on tcr_pkg and tetra_circumsphere_radius_top_assert.svh.
`default_nettype none

`include "tetra_circumsphere_radius_top_assert.svh"

module tcr_checker (
	input logic               clk,
	input logic               arst_n,
	input logic               in_ready,
	input logic               out_valid,
	input logic               out_ready,
	input tcr_pkg::out_beat_t out_data
);
	import tcr_pkg::*;

	`TCR_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_data))
	`TCR_ASSERT_NOW(a_ready_only_on_stall, !in_ready, out_valid && !out_ready)
	`TCR_ASSERT_NOW(a_degen_zero, out_valid && out_data.degenerate, !out_data.within_alpha && out_data.radius_q8 == '0 && out_data.center_x == '0 && out_data.center_y == '0 && out_data.center_z == '0)
	`TCR_ASSERT_NOW(a_alpha_not_degen, out_valid && out_data.within_alpha, !out_data.degenerate)

endmodule

bind tetra_circumsphere_radius_top tcr_checker u_tcr_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_ready  (in_ready),
	.out_valid (out_valid),
	.out_ready (out_ready),
	.out_data  (out_data)
);

`default_nettype wire

// ===== tb/sv/tetra_circumsphere_radius_checker.sv =====
// Scoreboard for the circumsphere radius block: tracks alpha writes, predicts
// each result on input beats and compares output beats in order.
// Depends on tcr_pkg.
`default_nettype none

module tetra_circumsphere_radius_checker (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	input  logic                        in_ready,
	input  tcr_pkg::in_beat_t           in_data,
	input  logic                        out_valid,
	input  logic                        out_ready,
	input  tcr_pkg::out_beat_t          out_data,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic                        pready,
	input  logic [tcr_pkg::ADDR_W-1:0]  paddr,
	input  logic [31:0]                 pwdata,
	output int                          fail_count,
	output int                          pending
);
	import tcr_pkg::*;

	typedef logic signed [127:0] wide_t;

	logic [RB-1:0] alpha_q8;
	out_beat_t     sphere_q[$];

	function automatic wide_t det3(input wide_t m[9]);
		return m[0] * (m[4] * m[8] - m[5] * m[7])
			- m[1] * (m[3] * m[8] - m[5] * m[6])
			+ m[2] * (m[3] * m[7] - m[4] * m[6]);
	endfunction

	function automatic out_beat_t sphere_of(input in_beat_t t, input logic [RB-1:0] alpha);
		wide_t            p[12];
		wide_t            rows[9];
		wide_t            m[9];
		wide_t            rhs[3];
		wide_t            det, q, dd;
		wide_t            ctr[3];
		logic [127:0]     sq, root, c;
		out_beat_t        r;
		p = '{wide_t'(t.a_x), wide_t'(t.a_y), wide_t'(t.a_z),
			wide_t'(t.b_x), wide_t'(t.b_y), wide_t'(t.b_z),
			wide_t'(t.c_x), wide_t'(t.c_y), wide_t'(t.c_z),
			wide_t'(t.d_x), wide_t'(t.d_y), wide_t'(t.d_z)};
		for (int i = 0; i < 3; i++) begin
			rhs[i] = 0;
			for (int j = 0; j < 3; j++) begin
				rows[i*3+j] = p[i*3+j] - p[9+j];
				rhs[i] += p[i*3+j] * p[i*3+j] - p[9+j] * p[9+j];
			end
		end
		r = '0;
		det = det3(rows);
		if (det == 0) begin
			r.degenerate = 1'b1;
			return r;
		end
		for (int col = 0; col < 3; col++) begin
			m = rows;
			for (int i = 0; i < 3; i++)
				m[i*3+col] = rhs[i];
			q = det3(m) / (2 * det);   // truncates toward zero
			if (q > 32767)
				q = 32767;
			else if (q < -32768)
				q = -32768;
			ctr[col] = q;
		end
		sq = 0;
		for (int j = 0; j < 3; j++) begin
			dd = ctr[j] - p[j];
			sq += dd * dd;
		end
		sq = sq << (2 * FB);
		root = 0;
		for (int b = 40; b >= 0; b--) begin
			c = root | (128'd1 << b);
			if (c * c <= sq)
				root = c;
		end
		r.radius_q8    = root[RB-1:0];
		r.center_x     = coord_t'(ctr[0]);
		r.center_y     = coord_t'(ctr[1]);
		r.center_z     = coord_t'(ctr[2]);
		r.within_alpha = (root[RB-1:0] < alpha);
		return r;
	endfunction

	assign pending = sphere_q.size();

	always @(posedge clk or negedge arst_n) begin
		out_beat_t want;
		if (!arst_n) begin
			alpha_q8   <= ALPHA_RESET;
			fail_count <= 0;
			sphere_q.delete();
		end else begin
			if (psel && penable && pwrite && pready && paddr[2] == REG_ALPHA)
				alpha_q8 <= pwdata[RB-1:0];
			if (in_valid && in_ready)
				sphere_q.insert(sphere_q.size(), sphere_of(in_data, alpha_q8));
			if (out_valid && out_ready) begin
				if (sphere_q.size() == 0) begin
					fail_count <= fail_count + 1;
					if (fail_count < 10)
						$display("unexpected result beat %p", out_data);
				end else begin
					want = sphere_q.pop_front();
					if (out_data !== want) begin
						fail_count <= fail_count + 1;
						if (fail_count < 10)
							$display("mismatch: expected %p got %p", want, out_data);
					end
				end
			end
		end
	end

endmodule

`default_nettype wire

// ===== tb/sv/tetra_circumsphere_radius_top_tb.sv =====
// Testbench top for the circumsphere radius block: clock, reset, stimulus,
// APB alpha writes and verdict. Depends on tcr_pkg, the top level and the checker module.
`default_nettype none

module tetra_circumsphere_radius_top_tb;
	import tcr_pkg::*;

	localparam int STALL_LIMIT = 2000;
	localparam int DRAIN_CYCLES = 80;

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              in_valid = 1'b0;
	logic              in_ready;
	in_beat_t          in_data = '0;
	logic              out_valid;
	logic              out_ready = 1'b0;
	out_beat_t         out_data;
	logic              psel = 1'b0;
	logic              penable = 1'b0;
	logic              pwrite = 1'b0;
	logic [ADDR_W-1:0] paddr = '0;
	logic [31:0]       pwdata = '0;
	logic [31:0]       prdata;
	logic              pready;
	int                fail_count;
	int                pending;
	int                idle_cycles = 0;
	int                stall_mode = 0;
	int                stall_tick = 0;

	always #5 clk = ~clk;

	tetra_circumsphere_radius_top u_top (
		.clk, .arst_n, .in_valid, .in_ready, .in_data, .out_valid, .out_ready,
		.out_data, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
	);

	tetra_circumsphere_radius_checker u_chk (
		.clk, .arst_n, .in_valid, .in_ready, .in_data, .out_valid, .out_ready,
		.out_data, .psel, .penable, .pwrite, .pready, .paddr, .pwdata,
		.fail_count, .pending
	);

	// receiver: switches between always ready, coin flip and long stalls
	always @(posedge clk) begin
		stall_tick <= stall_tick + 1;
		if (stall_tick % 97 == 0)
			stall_mode <= $urandom_range(0, 2);
		case (stall_mode)
			0: out_ready <= 1'b1;
			1: out_ready <= $urandom_range(0, 1);
			default: out_ready <= ($urandom_range(0, 7) == 0);
		endcase
	end

	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready) || psel)
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= STALL_LIMIT) begin
			$display("TEST FAILED");
			$finish;
		end
	end

	task automatic apb_write(input logic [ADDR_W-1:0] addr, input logic [31:0] data);
		@(posedge clk);
		psel <= 1'b1;
		pwrite <= 1'b1;
		paddr <= addr;
		pwdata <= data;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	// lets the pipe empty, then idles for DRAIN_CYCLES more
	task automatic drain();
		while (pending != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// one beat; leaves valid high so a following beat needs no re-raise
	task automatic send_tetra(input in_beat_t t);
		in_valid <= 1'b1;
		in_data <= t;
		do
			@(negedge clk);
		while (!in_ready);
		@(posedge clk);
	endtask

	task automatic gap(input int n);
		in_valid <= 1'b0;
		repeat (n) @(posedge clk);
	endtask

	function automatic coord_t near(input coord_t base, input int spread);
		int v;
		v = int'(base) + $urandom_range(0, 2 * spread) - spread;
		if (v > 32767) v = 32767;
		if (v < -32768) v = -32768;
		return coord_t'(v);
	endfunction

	function automatic in_beat_t rand_tetra();
		in_beat_t t;
		coord_t   cx, cy, cz;
		int       spread;
		int       kind;
		kind = $urandom_range(0, 9);
		t = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
		if (kind >= 4 && kind <= 7) begin
			// compact tetrahedron, radius around the alpha range
			spread = (kind == 7) ? 2000 : $urandom_range(1, 24);
			cx = coord_t'($urandom); cy = coord_t'($urandom); cz = coord_t'($urandom);
			t.a_x = near(cx, spread); t.a_y = near(cy, spread); t.a_z = near(cz, spread);
			t.b_x = near(cx, spread); t.b_y = near(cy, spread); t.b_z = near(cz, spread);
			t.c_x = near(cx, spread); t.c_y = near(cy, spread); t.c_z = near(cz, spread);
			t.d_x = near(cx, spread); t.d_y = near(cy, spread); t.d_z = near(cz, spread);
		end else if (kind == 8) begin
			// flat: coplanar or a repeated vertex
			if ($urandom_range(0, 1)) begin
				t.b_z = t.a_z; t.c_z = t.a_z; t.d_z = t.a_z;
			end else begin
				t.d_x = t.b_x; t.d_y = t.b_y; t.d_z = t.b_z;
			end
		end else if (kind == 9) begin
			// almost flat: centre runs past the coordinate range
			t.b_z = near(t.a_z, 1); t.c_z = near(t.a_z, 1); t.d_z = near(t.a_z, 1);
		end
		return t;
	endfunction

	initial begin
		int       burst;
		logic [31:0] alphas[5];
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// extremes, unit and flat cases, saturating centre
		send_tetra('0);
		send_tetra('1);
		send_tetra({12{16'sh7fff}});
		send_tetra({12{16'sh8000}});
		send_tetra({16'sd0, 16'sd0, 16'sd0, 16'sd1, 16'sd0, 16'sd0,
			16'sd0, 16'sd1, 16'sd0, 16'sd0, 16'sd0, 16'sd1});
		send_tetra({16'sd3, 16'sd3, 16'sd3, -16'sd3, -16'sd3, 16'sd3,
			-16'sd3, 16'sd3, -16'sd3, 16'sd3, -16'sd3, -16'sd3});
		send_tetra({16'sh8000, 16'sh8000, 16'sh8000, 16'sh7fff, 16'sh8000, 16'sh8000,
			16'sh8000, 16'sh7fff, 16'sh8000, 16'sh8000, 16'sh8000, 16'sh7fff});
		send_tetra({16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh8000, 16'sh7fff, 16'sh7fff,
			16'sh7fff, 16'sh8000, 16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh8000});
		send_tetra({16'sh8000, 16'sh8000, 16'sd0, 16'sh7fff, 16'sh8000, 16'sd0,
			16'sd0, 16'sh7fff, 16'sd0, 16'sd0, 16'sd0, 16'sd1});
		send_tetra({16'sh8000, 16'sh8000, 16'sd0, 16'sh7fff, 16'sh8000, 16'sd0,
			16'sd0, 16'sh7fff, 16'sd0, 16'sd0, 16'sd0, -16'sd1});
		send_tetra({16'sd5, 16'sd6, 16'sd7, 16'sd5, 16'sd6, 16'sd7,
			16'sd1, 16'sd2, 16'sd3, 16'sd9, 16'sd0, 16'sd4});
		send_tetra({16'sd0, 16'sd0, 16'sd0, 16'sd1, 16'sd1, 16'sd1,
			16'sd2, 16'sd2, 16'sd2, 16'sd7, 16'sd1, 16'sd9});
		send_tetra({16'sd10, 16'sd0, 16'sd0, -16'sd10, 16'sd0, 16'sd0,
			16'sd0, 16'sd10, 16'sd0, 16'sd0, 16'sd0, 16'sd10});
		send_tetra({16'sd11, 16'sd0, 16'sd0, -16'sd11, 16'sd0, 16'sd0,
			16'sd0, 16'sd11, 16'sd0, 16'sd0, 16'sd0, 16'sd11});
		gap(0);
		drain();

		// alpha sweep: zero, maximum, all ones, mid, back to reset value
		alphas = '{32'd0, 32'd29058560, 32'hffff_ffff, 32'd1000000, 32'd2560};
		for (int ph = 0; ph < 5; ph++) begin
			apb_write(3'd0, alphas[ph]);
			if (ph == 2)
				apb_write(3'd4, 32'd7);   // no register there, ignored
			for (int n = 0; n < 248;) begin
				burst = $urandom_range(1, 30);
				for (int k = 0; k < burst && n < 248; k++, n++)
					send_tetra(rand_tetra());
				if ($urandom_range(0, 3) != 0)
					gap($urandom_range(1, 6));
			end
			gap(0);
			drain();
		end

		if (fail_count == 0 && pending == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule

`default_nettype wire

// ===== tetra_circumsphere_radius_top.f =====
+incdir+src
src/tcr_pkg.sv
src/tcr_div_pipe.sv
src/tcr_sqrt_pipe.sv
src/tetra_circumsphere_radius_top.sv
src/tcr_checker.sv
tb/sv/tetra_circumsphere_radius_checker.sv
tb/sv/tetra_circumsphere_radius_top_tb.sv
